### hw/rtl/wlis_pkg.sv
// Shared types and constants for the weighted increasing/decreasing chain block.
package wlis_pkg;

  localparam int MAX_BUILDINGS = 1024;
  localparam int VALUE_BITS    = 16;

  localparam int HEIGHT_W = 16;
  localparam int WIDTH_W  = 16;
  localparam int SUM_W    = 26;
  localparam int ADDR_W   = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;
  localparam int CNT_W    = $clog2(MAX_BUILDINGS + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BUILDINGS);

  localparam logic [HEIGHT_W-1:0] HEIGHT_MASK = (VALUE_BITS >= HEIGHT_W) ? '1 :
      HEIGHT_W'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [WIDTH_W-1:0] WIDTH_MASK = (VALUE_BITS >= WIDTH_W) ? '1 :
      WIDTH_W'((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [SUM_W-1:0]    rise;
    logic [SUM_W-1:0]    fall;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [WIDTH_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

### hw/rtl/wlis_in_if.sv
// Input channel: one building word per handshake.
interface wlis_in_if import wlis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic [WIDTH_W-1:0]  width;
  logic                last_building;

  modport source (output valid, height, width, last_building, input ready);
  modport sink   (input valid, height, width, last_building, output ready);
endinterface

### hw/rtl/wlis_out_if.sv
// Output channel: one result word per case.
interface wlis_out_if import wlis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] best_increasing;
  logic [SUM_W-1:0] best_decreasing;
  logic             increasing_wins;
  logic             overflowed;

  modport source (output valid, best_increasing, best_decreasing, increasing_wins, overflowed,
                  input ready);
  modport sink   (input valid, best_increasing, best_decreasing, increasing_wins, overflowed,
                  output ready);
endinterface

### hw/rtl/wlis_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
module wlis_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 68
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/wlis_scan.sv
// Shared compare/max unit: folds one stored entry per cycle into the chain bests.
module wlis_scan import wlis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scan_ctrl_t          ctrl_i,
  input  entry_t              entry_i,
  input  logic [HEIGHT_W-1:0] height_i,
  output logic [SUM_W-1:0]    best_up_o,
  output logic [SUM_W-1:0]    best_down_o
);

  logic [SUM_W-1:0] best_up_q, best_up_d;
  logic [SUM_W-1:0] best_down_q, best_down_d;

  always_comb begin
    best_up_d   = best_up_q;
    best_down_d = best_down_q;
    if (ctrl_i.clr) begin
      best_up_d   = '0;
      best_down_d = '0;
    end else if (ctrl_i.vld) begin
      if ((entry_i.height < height_i) && (entry_i.rise > best_up_q)) begin
        best_up_d = entry_i.rise;
      end
      if ((entry_i.height > height_i) && (entry_i.fall > best_down_q)) begin
        best_down_d = entry_i.fall;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_up_q   <= '0;
      best_down_q <= '0;
    end else begin
      best_up_q   <= best_up_d;
      best_down_q <= best_down_d;
    end
  end

  assign best_up_o   = best_up_q;
  assign best_down_o = best_down_q;

endmodule

### hw/rtl/weighted_lis_lds.sv
// Top level: sequencer, case state and result register.
//
// Takes one building per word and, for each, scans all earlier buildings of the
// current case through the single read port of the entry memory, one entry per
// cycle, in a shared compare/max unit. A building that finds buildings already
// stored passes through the scan, drain and update states (only update when none
// are stored); a building dropped because the store is full writes nothing. The
// word marked last then passes the finish state, which loads the result register
// and waits while the previous result is held. Ready is low while a building is
// being processed. A result word appears only for a building marked last; it
// holds the best increasing and decreasing width sums, whether increasing is at
// least decreasing, and whether buildings past MAX_BUILDINGS were dropped. After
// the result is loaded the case state clears; the memory needs no clearing.
module weighted_lis_lds import wlis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wlis_in_if.sink    bld_i,
  wlis_out_if.source res_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    rise_max_q, rise_max_d;
  logic [SUM_W-1:0]    fall_max_q, fall_max_d;
  logic                ovf_q, ovf_d;
  logic [HEIGHT_W-1:0] h_q, h_d;
  logic [WIDTH_W-1:0]  w_q, w_d;
  logic                last_q, last_d;
  logic                rd_vld_q;

  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_inc_q, out_dec_q;
  logic             out_wins_q, out_ovf_q;
  logic             out_load;

  logic             accept;
  logic             rd_en, wr_en;
  scan_ctrl_t       scan_ctrl;
  entry_t           rd_entry, wr_entry;
  logic [SUM_W-1:0] best_up, best_down;
  logic [SUM_W-1:0] rise_new, fall_new;

  assign accept    = bld_i.valid && bld_i.ready;
  assign rise_new  = sat_add(best_up, w_q);
  assign fall_new  = sat_add(best_down, w_q);
  assign wr_entry  = '{height: h_q, rise: rise_new, fall: fall_new};
  assign bld_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rise_max_d = rise_max_q;
    fall_max_d = fall_max_q;
    ovf_d      = ovf_q;
    h_d        = h_q;
    w_d        = w_q;
    last_d     = last_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    scan_ctrl  = '{clr: 1'b0, vld: rd_vld_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          h_d           = bld_i.height & HEIGHT_MASK;
          w_d           = bld_i.width & WIDTH_MASK;
          last_d        = bld_i.last_building;
          idx_d         = '0;
          scan_ctrl.clr = 1'b1;
          if (count_q == CNT_FULL) begin
            ovf_d   = 1'b1;
            state_d = bld_i.last_building ? ST_FINISH : ST_IDLE;
          end else if (count_q == '0) begin
            state_d = ST_UPDATE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == count_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
        if (rise_new > rise_max_q) begin
          rise_max_d = rise_new;
        end
        if (fall_new > fall_max_q) begin
          fall_max_d = fall_new;
        end
        state_d = last_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_load   = 1'b1;
          count_d    = '0;
          rise_max_d = '0;
          fall_max_d = '0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rise_max_q  <= '0;
      fall_max_q  <= '0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rise_max_q  <= rise_max_d;
      fall_max_q  <= fall_max_d;
      ovf_q       <= ovf_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    w_q    <= w_d;
    last_q <= last_d;
    if (out_load) begin
      out_inc_q  <= rise_max_q;
      out_dec_q  <= fall_max_q;
      out_wins_q <= (rise_max_q >= fall_max_q);
      out_ovf_q  <= ovf_q;
    end
  end

  wlis_ram #(
    .DEPTH (MAX_BUILDINGS),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rd_entry)
  );

  wlis_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .entry_i     (rd_entry),
    .height_i    (h_q),
    .best_up_o   (best_up),
    .best_down_o (best_down)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.best_increasing = out_inc_q;
  assign res_o.best_decreasing = out_dec_q;
  assign res_o.increasing_wins = out_wins_q;
  assign res_o.overflowed      = out_ovf_q;

endmodule

### tb/sv/tb_weighted_lis_lds.sv
// Self-checking testbench for weighted_lis_lds: directed table, store-full case, random cases.
`timescale 1ns / 100ps

module tb_weighted_lis_lds;
  import wlis_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 580;
  localparam int HOLD_CYCLES  = 2000;
  localparam int N_DIRECTED   = 17;

  typedef struct packed {
    logic [SUM_W-1:0] best_inc;
    logic [SUM_W-1:0] best_dec;
    logic             inc_wins;
    logic             ovf;
  } case_result_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
    logic                last;
    logic                typed;
    case_result_t        want;
  } stim_row_t;

  typedef enum int {SHAPE_NOISE, SHAPE_CLUSTER, SHAPE_RISING, SHAPE_FALLING} shape_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE, RX_CHOKE} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  wlis_in_if  bld ();
  wlis_out_if res ();

  weighted_lis_lds dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bld_i  (bld),
    .res_o  (res)
  );

  // height, width, last, typed, {best_inc, best_dec, inc_wins, ovf}
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'd0,      16'd0,      1'b1, 1'b1, '{26'd0,     26'd0,     1'b1, 1'b0}},
    '{16'hFFFF,   16'hFFFF,   1'b1, 1'b1, '{26'd65535, 26'd65535, 1'b1, 1'b0}},
    '{16'd1,      16'd10,     1'b0, 1'b0, '0},
    '{16'd2,      16'd20,     1'b0, 1'b0, '0},
    '{16'd3,      16'd30,     1'b1, 1'b1, '{26'd60,    26'd30,    1'b1, 1'b0}},
    '{16'd3,      16'd10,     1'b0, 1'b0, '0},
    '{16'd2,      16'd20,     1'b0, 1'b0, '0},
    '{16'd1,      16'd5,      1'b1, 1'b1, '{26'd20,    26'd35,    1'b0, 1'b0}},
    '{16'd5,      16'd7,      1'b0, 1'b0, '0},
    '{16'd5,      16'd9,      1'b1, 1'b1, '{26'd9,     26'd9,     1'b1, 1'b0}},
    '{16'd100,    16'd1,      1'b0, 1'b0, '0},
    '{16'd50,     16'hFFFF,   1'b0, 1'b0, '0},
    '{16'd200,    16'd3,      1'b0, 1'b0, '0},
    '{16'd0,      16'hFFFF,   1'b0, 1'b0, '0},
    '{16'hFFFF,   16'd1,      1'b1, 1'b0, '0},
    '{16'hAAAA,   16'h5555,   1'b0, 1'b0, '0},
    '{16'h5555,   16'hAAAA,   1'b1, 1'b0, '0}
  };

  // chain state of the current case
  logic [HEIGHT_W-1:0] height_log [MAX_BUILDINGS];
  logic [SUM_W-1:0]    rise_log   [MAX_BUILDINGS];
  logic [SUM_W-1:0]    fall_log   [MAX_BUILDINGS];
  int                  stored_cnt  = 0;
  logic [SUM_W-1:0]    rise_peak   = '0;
  logic [SUM_W-1:0]    fall_peak   = '0;
  logic                dropped_any = 1'b0;

  case_result_t pending_results [$];
  int           mismatch_cnt = 0;
  int           burst_left   = 1;
  int           cycle_cnt    = 0;
  bit           hold_go      = 1'b0;
  bit           hold_done    = 1'b0;

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] base, logic [WIDTH_W-1:0] w);
    logic [SUM_W:0] total;
    total = {1'b0, base} + (SUM_W+1)'(w);
    return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  endfunction

  function automatic bit fold_building(input logic [HEIGHT_W-1:0] h_in,
                                       input logic [WIDTH_W-1:0] w_in, input logic last,
                                       output case_result_t result_out);
    logic [HEIGHT_W-1:0] h;
    logic [WIDTH_W-1:0]  w;
    logic [SUM_W-1:0]    up;
    logic [SUM_W-1:0]    down;
    logic [SUM_W-1:0]    rise;
    logic [SUM_W-1:0]    fall;
    h          = h_in & HEIGHT_MASK;
    w          = w_in & WIDTH_MASK;
    result_out = '0;
    if (stored_cnt < MAX_BUILDINGS) begin
      up   = '0;
      down = '0;
      for (int k = 0; k < stored_cnt; k++) begin
        if (height_log[k] < h && rise_log[k] > up) up = rise_log[k];
        if (height_log[k] > h && fall_log[k] > down) down = fall_log[k];
      end
      rise = sum_sat(up, w);
      fall = sum_sat(down, w);
      height_log[stored_cnt] = h;
      rise_log[stored_cnt]   = rise;
      fall_log[stored_cnt]   = fall;
      stored_cnt++;
      if (rise > rise_peak) rise_peak = rise;
      if (fall > fall_peak) fall_peak = fall;
    end else begin
      dropped_any = 1'b1;
    end
    if (!last) return 1'b0;
    result_out  = '{rise_peak, fall_peak, rise_peak >= fall_peak, dropped_any};
    stored_cnt  = 0;
    rise_peak   = '0;
    fall_peak   = '0;
    dropped_any = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_cnt++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_building(input logic [HEIGHT_W-1:0] h, input logic [WIDTH_W-1:0] w,
                               input logic last, input logic typed, input case_result_t want);
    case_result_t predicted;
    int           gap;
    bld.valid         <= 1'b1;
    bld.height        <= h;
    bld.width         <= w;
    bld.last_building <= last;
    do @(posedge clk_i); while (!bld.ready);
    if (fold_building(h, w, last, predicted))
      pending_results = {pending_results, (typed ? want : predicted)};
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        bld.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    bld.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int                  sent;
    int                  len;
    shape_e              shape;
    logic [HEIGHT_W-1:0] h;
    logic [WIDTH_W-1:0]  w;
    bld.valid         <= 1'b0;
    bld.height        <= '0;
    bld.width         <= '0;
    bld.last_building <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_building(directed_rows[i].height, directed_rows[i].width, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // fill the store with a rising run, then two dropped words, the second one last
    for (int i = 0; i < MAX_BUILDINGS; i++)
      send_building(HEIGHT_W'(i), '1, 1'b0, 1'b0, '0);
    send_building(16'd5000, 16'd1, 1'b0, 1'b0, '0);
    send_building(16'd7, 16'd7, 1'b1, 1'b1, '{26'd67107840, 26'd65535, 1'b1, 1'b1});
    drain_results();

    hold_go = 1'b1;
    sent    = 0;
    h       = '0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(41, 120);
        1, 2, 3: len = $urandom_range(11, 40);
        default: len = $urandom_range(1, 10);
      endcase
      shape = shape_e'($urandom_range(0, 3));
      for (int j = 0; j < len; j++) begin
        case (shape)
          SHAPE_NOISE:   h = HEIGHT_W'($urandom);
          SHAPE_CLUSTER: h = HEIGHT_W'($urandom_range(0, 7));
          SHAPE_RISING:  h = (j == 0) ? HEIGHT_W'($urandom_range(0, 60000))
                                      : h + HEIGHT_W'($urandom_range(0, 300));
          default:       h = (j == 0) ? HEIGHT_W'($urandom_range(5000, 65535))
                                      : h - HEIGHT_W'($urandom_range(0, 300));
        endcase
        if (shape != SHAPE_NOISE && $urandom_range(0, 9) == 0) h = HEIGHT_W'($urandom);
        case ($urandom_range(0, 5))
          0:       w = '1;
          1:       w = '0;
          2, 3:    w = WIDTH_W'($urandom);
          default: w = WIDTH_W'($urandom_range(1, 15));
        endcase
        send_building(h, w, j == len - 1, 1'b0, '0);
        sent++;
      end
    end
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_e mode;
    int       run;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = rx_mode_e'($urandom_range(0, 3));
        run  = $urandom_range(16, 160);
        repeat (run) begin
          case (mode)
            RX_OPEN:    res.ready <= 1'b1;
            RX_COIN:    res.ready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: res.ready <= ($urandom_range(0, 3) == 0);
            default:    res.ready <= ($urandom_range(0, 15) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    case_result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with none pending", 32'(res.best_increasing), 0);
      end else begin
        want = pending_results.pop_front();
        if (res.best_increasing !== want.best_inc)
          flag_mismatch("best_increasing", 32'(res.best_increasing), 32'(want.best_inc));
        if (res.best_decreasing !== want.best_dec)
          flag_mismatch("best_decreasing", 32'(res.best_decreasing), 32'(want.best_dec));
        if (res.increasing_wins !== want.inc_wins)
          flag_mismatch("increasing_wins", 32'(res.increasing_wins), 32'(want.inc_wins));
        if (res.overflowed !== want.ovf)
          flag_mismatch("overflowed", 32'(res.overflowed), 32'(want.ovf));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
